// ===== hw/rtl/sads_pkg.sv =====
package sads_pkg;

    // Number of entries shared by the two stacks.
    localparam int STORE_DEPTH = 128;

    // Address and count widths follow the store depth.
    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int CNT_W  = $clog2(STORE_DEPTH + 1);

    // Fixed field widths of the transactions.
    localparam int DATA_W  = 32;
    localparam int SEL_W   = 2;
    localparam int STAT_W  = 2;
    localparam int TOTAL_W = 8;

    typedef logic [STAT_W-1:0] status_t;
    typedef logic [SEL_W-1:0]  sel_t;

    // Result status codes.
    localparam status_t ST_OK     = 2'd0;
    localparam status_t ST_FULL   = 2'd1;
    localparam status_t ST_EMPTY  = 2'd2;
    localparam status_t ST_BADSEL = 2'd3;

    // Operation and stack select codes.
    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;
    localparam sel_t SEL_LOWER = 2'd1;
    localparam sel_t SEL_UPPER = 2'd2;

    // Controller commands to the datapath.
    typedef struct packed {
        logic exec;
        logic load_result;
    } sads_cmd_t;

endpackage

// ===== hw/rtl/shared_array_double_stack.sv =====
// Two stacks sharing one element store. The lower stack grows up from the
// first entry and the upper stack grows down from the last entry.
// Input channel (in_valid/in_ready): action (push or pop), stack_select and
// push_value. Output channel (out_valid/out_ready): status, popped_value and
// total_count, exactly one result transaction per input transaction.
// The result appears in the cycle after the input is accepted; the result
// register and the store's registered read port put it there.
// Throughput: one transaction per cycle while out_ready stays high; a new
// input is accepted in the same cycle the pending result is taken.
// When the receiver stalls, the result is held and in_ready drops until the
// result is taken, so at most one result is ever waiting.
// Reset clears both stack pointers and the element total; the store itself
// is not cleared, since an entry is only read after it was written. No
// clearing pass is needed, so inputs are taken right after reset.
// A push to a full store reports full first, even with a bad stack number.
module shared_array_double_stack (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               action,
    input  logic [sads_pkg::SEL_W-1:0]         stack_select,
    input  logic signed [sads_pkg::DATA_W-1:0] push_value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [sads_pkg::STAT_W-1:0]        status,
    output logic signed [sads_pkg::DATA_W-1:0] popped_value,
    output logic [sads_pkg::TOTAL_W-1:0]       total_count
);
    import sads_pkg::*;

    sads_cmd_t cmd;

    sads_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    sads_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .action       (action),
        .stack_select (stack_select),
        .push_value   (push_value),
        .status       (status),
        .popped_value (popped_value),
        .total_count  (total_count)
    );

    // The element total never exceeds the store depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        total_count <= TOTAL_W'(STORE_DEPTH))
        else $error("element total exceeds store depth");

    // A full report is only given when the store really is full.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_FULL) |-> (total_count == TOTAL_W'(STORE_DEPTH)))
        else $error("full status with free entries");

    // Failed operations return no data.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |-> (popped_value == '0))
        else $error("failed operation returned data");

    // Every accepted transaction produces a result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> out_valid)
        else $error("accepted transaction produced no result");

endmodule

// ===== hw/rtl/sads_ctrl.sv =====
module sads_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output sads_pkg::sads_cmd_t cmd
);
    import sads_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RESP = 1'b1;

    logic state_reg;
    logic state_next;
    logic accept;

    // A new transaction is taken whenever the result register is empty or
    // is being emptied in the same cycle.
    always_comb
    begin
        case (state_reg)
            S_IDLE:  in_ready = 1'b1;
            S_RESP:  in_ready = out_ready;
            default: in_ready = 1'b0;
        endcase
    end

    assign accept    = in_valid && in_ready;
    assign out_valid = (state_reg == S_RESP);

    always_comb
    begin
        cmd.exec        = accept;
        cmd.load_result = accept;
    end

    // Next state: stay in RESP while results keep arriving back to back or the receiver stalls.
    always_comb
    begin
        case (state_reg)
            S_IDLE:  state_next = accept ? S_RESP : S_IDLE;
            S_RESP:
            begin
                if (accept)
                    state_next = S_RESP;
                else if (out_ready)
                    state_next = S_IDLE;
                else
                    state_next = S_RESP;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== hw/rtl/sads_dpath.sv =====
module sads_dpath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sads_pkg::sads_cmd_t           cmd,
    input  logic                          action,
    input  logic [sads_pkg::SEL_W-1:0]    stack_select,
    input  logic signed [sads_pkg::DATA_W-1:0] push_value,
    output logic [sads_pkg::STAT_W-1:0]   status,
    output logic signed [sads_pkg::DATA_W-1:0] popped_value,
    output logic [sads_pkg::TOTAL_W-1:0]  total_count
);
    import sads_pkg::*;

    logic [DATA_W-1:0] mem [STORE_DEPTH];

    logic [CNT_W-1:0]  lower_cnt_reg, lower_cnt_next;
    logic [CNT_W-1:0]  upper_cnt_reg, upper_cnt_next;
    logic [CNT_W-1:0]  total_reg, total_next;
    status_t           status_reg, status_next;
    logic              pop_ok_reg, pop_ok_next;
    logic [DATA_W-1:0] rd_data_reg;

    logic [CNT_W:0]    sum;
    logic              full;
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;

    assign sum  = {1'b0, lower_cnt_reg} + {1'b0, upper_cnt_reg};
    assign full = (sum >= (CNT_W+1)'(STORE_DEPTH));

    // Decode the operation: status, pointer updates and store access.
    always_comb
    begin
        lower_cnt_next = lower_cnt_reg;
        upper_cnt_next = upper_cnt_reg;
        status_next    = ST_OK;
        pop_ok_next    = 1'b0;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        wr_addr        = lower_cnt_reg[ADDR_W-1:0];
        rd_addr        = ADDR_W'(lower_cnt_reg - CNT_W'(1));
        if (action == ACT_PUSH)
        begin
            if (full)
                status_next = ST_FULL;
            else if (stack_select == SEL_LOWER)
            begin
                wr_en          = 1'b1;
                wr_addr        = lower_cnt_reg[ADDR_W-1:0];
                lower_cnt_next = lower_cnt_reg + CNT_W'(1);
            end
            else if (stack_select == SEL_UPPER)
            begin
                wr_en          = 1'b1;
                wr_addr        = ADDR_W'(CNT_W'(STORE_DEPTH - 1) - upper_cnt_reg);
                upper_cnt_next = upper_cnt_reg + CNT_W'(1);
            end
            else
                status_next = ST_BADSEL;
        end
        else
        begin
            if (stack_select == SEL_LOWER)
            begin
                if (lower_cnt_reg == '0)
                    status_next = ST_EMPTY;
                else
                begin
                    rd_en          = 1'b1;
                    pop_ok_next    = 1'b1;
                    rd_addr        = ADDR_W'(lower_cnt_reg - CNT_W'(1));
                    lower_cnt_next = lower_cnt_reg - CNT_W'(1);
                end
            end
            else if (stack_select == SEL_UPPER)
            begin
                if (upper_cnt_reg == '0)
                    status_next = ST_EMPTY;
                else
                begin
                    rd_en          = 1'b1;
                    pop_ok_next    = 1'b1;
                    rd_addr        = ADDR_W'(CNT_W'(STORE_DEPTH) - upper_cnt_reg);
                    upper_cnt_next = upper_cnt_reg - CNT_W'(1);
                end
            end
            else
                status_next = ST_BADSEL;
        end
        total_next = CNT_W'(({1'b0, lower_cnt_next} + {1'b0, upper_cnt_next}));
    end

    // Shared element store with a registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.exec && wr_en)
            mem[wr_addr] <= push_value;
        if (cmd.exec && rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    // Stack pointers and the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_cnt_reg <= '0;
            upper_cnt_reg <= '0;
            total_reg     <= '0;
            status_reg    <= ST_OK;
            pop_ok_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.exec)
            begin
                lower_cnt_reg <= lower_cnt_next;
                upper_cnt_reg <= upper_cnt_next;
            end
            if (cmd.load_result)
            begin
                total_reg  <= total_next;
                status_reg <= status_next;
                pop_ok_reg <= pop_ok_next;
            end
        end
    end

    assign status       = status_reg;
    assign popped_value = pop_ok_reg ? rd_data_reg : '0;
    assign total_count  = TOTAL_W'(total_reg);

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import sads_pkg::*;

    // Stack select codes that address no stack.
    localparam sel_t SEL_NONE  = 2'd0;
    localparam sel_t SEL_SPARE = 2'd3;

    typedef struct packed {
        status_t            status;
        logic signed [31:0] popped;
        logic [7:0]         total;
    } stack_result_t;

    // One row of directed stimulus; rows with more than one repeat use random values.
    typedef struct packed {
        logic               act;
        sel_t               sel;
        logic signed [31:0] val;
        logic [7:0]         reps;
        logic               typed;
        stack_result_t      want;
    } stack_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               action = ACT_PUSH;
    sel_t               stack_select = SEL_NONE;
    logic signed [31:0] push_value = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    status_t            status;
    logic signed [31:0] popped_value;
    logic [7:0]         total_count;

    // Typed expectation that travels with the transaction on the input channel.
    logic               row_typed = 1'b0;
    stack_result_t      row_want = '0;

    int send_idle_pct = 9;
    int recv_idle_pct = 63;
    int mismatch_count = 0;

    // Shadow copy of both stacks.
    logic signed [31:0] shadow_store [0:STORE_DEPTH-1];
    int                 lower_held = 0;
    int                 upper_held = 0;

    stack_result_t awaited_results [$];

    stack_row_t directed_ops [0:24] = '{
        '{ACT_POP,  SEL_LOWER, 32'h0,        8'd1,  1'b1, '{ST_EMPTY,  32'h0,        8'd0}},
        '{ACT_POP,  SEL_UPPER, 32'h0,        8'd1,  1'b1, '{ST_EMPTY,  32'h0,        8'd0}},
        '{ACT_PUSH, SEL_NONE,  32'h12345678, 8'd1,  1'b1, '{ST_BADSEL, 32'h0,        8'd0}},
        '{ACT_PUSH, SEL_SPARE, 32'hedcba987, 8'd1,  1'b1, '{ST_BADSEL, 32'h0,        8'd0}},
        '{ACT_POP,  SEL_NONE,  32'h0,        8'd1,  1'b1, '{ST_BADSEL, 32'h0,        8'd0}},
        '{ACT_POP,  SEL_SPARE, 32'h0,        8'd1,  1'b1, '{ST_BADSEL, 32'h0,        8'd0}},
        '{ACT_PUSH, SEL_LOWER, 32'h7fffffff, 8'd1,  1'b1, '{ST_OK,     32'h0,        8'd1}},
        '{ACT_PUSH, SEL_UPPER, 32'h80000000, 8'd1,  1'b1, '{ST_OK,     32'h0,        8'd2}},
        '{ACT_PUSH, SEL_LOWER, 32'hffffffff, 8'd1,  1'b1, '{ST_OK,     32'h0,        8'd3}},
        '{ACT_PUSH, SEL_UPPER, 32'h0,        8'd1,  1'b1, '{ST_OK,     32'h0,        8'd4}},
        '{ACT_POP,  SEL_UPPER, 32'h0,        8'd1,  1'b1, '{ST_OK,     32'h0,        8'd3}},
        '{ACT_POP,  SEL_UPPER, 32'h0,        8'd1,  1'b1, '{ST_OK,     32'h80000000, 8'd2}},
        '{ACT_POP,  SEL_UPPER, 32'h0,        8'd1,  1'b1, '{ST_EMPTY,  32'h0,        8'd2}},
        '{ACT_POP,  SEL_LOWER, 32'h0,        8'd1,  1'b1, '{ST_OK,     32'hffffffff, 8'd1}},
        '{ACT_POP,  SEL_LOWER, 32'h0,        8'd1,  1'b1, '{ST_OK,     32'h7fffffff, 8'd0}},
        '{ACT_PUSH, SEL_LOWER, 32'h0,        8'd60, 1'b0, '{ST_OK,     32'h0,        8'd0}},
        '{ACT_PUSH, SEL_UPPER, 32'h0,        8'd68, 1'b0, '{ST_OK,     32'h0,        8'd0}},
        '{ACT_PUSH, SEL_SPARE, 32'h55aa55aa, 8'd1,  1'b1, '{ST_FULL,   32'h0,        8'd128}},
        '{ACT_PUSH, SEL_NONE,  32'haa55aa55, 8'd1,  1'b1, '{ST_FULL,   32'h0,        8'd128}},
        '{ACT_PUSH, SEL_LOWER, 32'h1,        8'd1,  1'b1, '{ST_FULL,   32'h0,        8'd128}},
        '{ACT_PUSH, SEL_UPPER, 32'h2,        8'd1,  1'b1, '{ST_FULL,   32'h0,        8'd128}},
        '{ACT_POP,  SEL_SPARE, 32'h0,        8'd1,  1'b1, '{ST_BADSEL, 32'h0,        8'd128}},
        '{ACT_POP,  SEL_UPPER, 32'h0,        8'd1,  1'b0, '{ST_OK,     32'h0,        8'd0}},
        '{ACT_POP,  SEL_LOWER, 32'h0,        8'd1,  1'b0, '{ST_OK,     32'h0,        8'd0}},
        '{ACT_PUSH, SEL_NONE,  32'h3,        8'd1,  1'b1, '{ST_BADSEL, 32'h0,        8'd126}}
    };

    shared_array_double_stack dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .stack_select (stack_select),
        .push_value   (push_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .popped_value (popped_value),
        .total_count  (total_count)
    );

    always #4 clk = ~clk;

    // Applies one push or pop to the shadow stacks and returns the result it should give.
    function automatic stack_result_t predict_stack_op(logic act, sel_t sel,
                                                       logic signed [31:0] val);
        stack_result_t r;
        r.status = ST_OK;
        r.popped = '0;
        if (act == ACT_PUSH)
        begin
            if (lower_held + upper_held >= STORE_DEPTH)
            begin
                r.status = ST_FULL;
            end
            else if (sel == SEL_LOWER)
            begin
                shadow_store[lower_held] = val;
                lower_held++;
            end
            else if (sel == SEL_UPPER)
            begin
                shadow_store[STORE_DEPTH - 1 - upper_held] = val;
                upper_held++;
            end
            else
            begin
                r.status = ST_BADSEL;
            end
        end
        else if (sel == SEL_LOWER)
        begin
            if (lower_held == 0)
            begin
                r.status = ST_EMPTY;
            end
            else
            begin
                lower_held--;
                r.popped = shadow_store[lower_held];
            end
        end
        else if (sel == SEL_UPPER)
        begin
            if (upper_held == 0)
            begin
                r.status = ST_EMPTY;
            end
            else
            begin
                r.popped = shadow_store[STORE_DEPTH - upper_held];
                upper_held--;
            end
        end
        else
        begin
            r.status = ST_BADSEL;
        end
        r.total = 8'(lower_held + upper_held);
        return r;
    endfunction

    // Receiver stalls at the rate of the current phase.
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Check each result transaction, then record the expectation of each input transaction.
    always @(posedge clk)
    begin
        stack_result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("unexpected result: status %0d popped %0d total %0d",
                           status, popped_value, total_count);
                    mismatch_count++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        mismatch_count++;
                    end
                    if (popped_value !== want.popped)
                    begin
                        $error("popped_value: expected %0d, got %0d", want.popped, popped_value);
                        mismatch_count++;
                    end
                    if (total_count !== want.total)
                    begin
                        $error("total_count: expected %0d, got %0d", want.total, total_count);
                        mismatch_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                want = predict_stack_op(action, stack_select, push_value);
                if (row_typed)
                    want = row_want;
                awaited_results.push_back(want);
            end
        end
    end

    // Present one transaction after any sender gap and wait until it is taken.
    task automatic send_op(logic act, sel_t sel, logic signed [31:0] val,
                           logic typed, stack_result_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        action       <= act;
        stack_select <= sel;
        push_value   <= val;
        row_typed    <= typed;
        row_want     <= want;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Bursts biased toward filling, draining or churning, aimed at one or both stacks.
    task automatic run_random_ops(int count);
        int                 done;
        int                 burst;
        int                 push_pct;
        int                 lower_pct;
        logic               act;
        sel_t               sel;
        logic signed [31:0] val;
        done = 0;
        while (done < count)
        begin
            burst = $urandom_range(120, 4);
            case ($urandom_range(2))
                0: push_pct = 85;
                1: push_pct = 15;
                default: push_pct = 50;
            endcase
            case ($urandom_range(3))
                0: lower_pct = 0;
                1: lower_pct = 100;
                2: lower_pct = 50;
                default: lower_pct = $urandom_range(100);
            endcase
            for (int i = 0; i < burst && done < count; i++)
            begin
                act = ($urandom_range(99) < push_pct) ? ACT_PUSH : ACT_POP;
                if ($urandom_range(99) < 6)
                    sel = $urandom_range(1) ? SEL_SPARE : SEL_NONE;
                else
                    sel = ($urandom_range(99) < lower_pct) ? SEL_LOWER : SEL_UPPER;
                case ($urandom_range(11))
                    0: val = 32'h7fffffff;
                    1: val = 32'h80000000;
                    2: val = '0;
                    3: val = '1;
                    default: val = $urandom;
                endcase
                send_op(act, sel, val, 1'b0, '0);
                done++;
            end
        end
    endtask

    // Main sequence: reset, directed rows, then three phases of random traffic with different idle rates.
    initial
    begin
        logic signed [31:0] val;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_ops[i])
        begin
            for (int r = 0; r < directed_ops[i].reps; r++)
            begin
                val = (directed_ops[i].reps > 1) ? $urandom : directed_ops[i].val;
                send_op(directed_ops[i].act, directed_ops[i].sel, val,
                        directed_ops[i].typed, directed_ops[i].want);
            end
        end

        run_random_ops(320);
        send_idle_pct <= 63;
        recv_idle_pct <= 9;
        run_random_ops(320);
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        run_random_ops(320);

        in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        if (mismatch_count == 0)
            $display("shared_array_double_stack regression: pass");
        else
            $display("shared_array_double_stack regression: fail");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #2000000;
        $display("shared_array_double_stack regression: fail");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/sads_pkg.sv
hw/rtl/sads_ctrl.sv
hw/rtl/sads_dpath.sv
hw/rtl/shared_array_double_stack.sv
dv/testbench.sv
